// File: sv/fsnds_pkg.sv
// Package for the short-name directory scanner.
// Holds shared constants, the config and result types, and the FIFO depth.
// No dependencies.
package fsnds_pkg;

  localparam int MAX_DIR_ENTRIES = 65536;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 5;
  localparam int CNT_W    = 16;
  localparam int WORD_W   = 32;
  localparam int HEAD_W   = 64;
  localparam int TAIL_W   = 24;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 2;

  // Last legal entry index; the scan ends after this entry.
  localparam logic [CNT_W-1:0] ENTRY_LAST = CNT_W'(MAX_DIR_ENTRIES - 1);

  // Register indexes on the config port.
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_HEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_TAIL = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_LISTED = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_END    = 2'd2;

  // Result FIFO depth (power of two, room for two pushes per beat).
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic              scan_mode;
    logic [HEAD_W-1:0] name_head;
    logic [TAIL_W-1:0] name_tail;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CNT_W-1:0]  entry_index;
    logic [CNT_W-1:0]  listed_count;
    logic [BYTE_W-1:0] attr_bits;
    logic [WORD_W-1:0] start_cluster;
    logic [WORD_W-1:0] file_size;
    logic              scan_done;
  } result_t;

  // Up to two results from one directory byte, in delivery order.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } result_pair_t;

endpackage

// File: sv/fat_short_name_dir_scanner.sv
// Top level of the short-name directory scanner: config registers, input
// register, scan core and result FIFO. Depends on fsnds_pkg, fsnds_core,
// fsnds_fifo.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | in_valid / in_stall  | dir_byte, last_byte
//   result   | out_valid / out_stall| status, entry_index, listed_count,
//            |                      | attr_bits, start_cluster, file_size,
//            |                      | scan_done
//   config   | cfg_we (no wait)     | cfg_index, cfg_data
//
// One directory byte per cycle while in_stall is low. A byte is held in the input
// register, is scanned there and its results (zero, one or two) are registered
// into a 4-deep FIFO, whose head drives the outputs. A byte leaves the input
// register only when the FIFO has room for two results; a byte that yields two
// results puts both in the FIFO, which hands them out one per beat.
// Reset (rst, synchronous) empties both stages, zeroes config, starts a fresh
// scan. out_stall only backs up the FIFO; in_stall rises once it is near full.
module fat_short_name_dir_scanner (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fsnds_pkg::BYTE_W-1:0]      dir_byte,
  input  logic                              last_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [fsnds_pkg::CNT_W-1:0]       entry_index,
  output logic [fsnds_pkg::CNT_W-1:0]       listed_count,
  output logic [fsnds_pkg::BYTE_W-1:0]      attr_bits,
  output logic [fsnds_pkg::WORD_W-1:0]      start_cluster,
  output logic [fsnds_pkg::WORD_W-1:0]      file_size,
  output logic                              scan_done,
  input  logic                              cfg_we,
  input  logic [fsnds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsnds_pkg::CFG_W-1:0]       cfg_data
);
  import fsnds_pkg::*;

  cfg_t         cfg;
  logic         in_full;
  logic [BYTE_W-1:0] in_byte;
  logic         in_last;
  logic         go;
  logic         room2;
  logic         accept;
  result_pair_t res;
  result_t      head;

  // Config registers; index 3 is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCAN_MODE: cfg.scan_mode <= cfg_data[0];
        REG_NAME_HEAD: cfg.name_head <= cfg_data;
        REG_NAME_TAIL: cfg.name_tail <= cfg_data[TAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: scanned when the FIFO can take two results.
  assign go       = in_full && room2;
  assign in_stall = in_full && !room2;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= accept || (in_full && !go);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= dir_byte;
      in_last <= last_byte;
    end
  end

  fsnds_core u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .dir_byte (in_byte),
    .last_byte(in_last),
    .cfg      (cfg),
    .res      (res)
  );

  fsnds_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res),
    .pop      (out_valid && !out_stall),
    .room2    (room2),
    .not_empty(out_valid),
    .head     (head)
  );

  assign status        = head.status;
  assign entry_index   = head.entry_index;
  assign listed_count  = head.listed_count;
  assign attr_bits     = head.attr_bits;
  assign start_cluster = head.start_cluster;
  assign file_size     = head.file_size;
  assign scan_done     = head.scan_done;

endmodule

// File: sv/fsnds_core.sv
// Scan state and per-byte result logic of the short-name directory scanner.
// Depends on fsnds_pkg.
module fsnds_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [fsnds_pkg::BYTE_W-1:0] dir_byte,
  input  logic                        last_byte,
  input  fsnds_pkg::cfg_t             cfg,
  output fsnds_pkg::result_pair_t     res
);
  import fsnds_pkg::*;

  typedef enum logic [1:0] {
    PH_ACTIVE = 2'b01,
    PH_DRAIN  = 2'b10
  } phase_t;

  phase_t             scan_phase, scan_phase_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [CNT_W-1:0]   entry_counter, entry_counter_next;
  logic [CNT_W-1:0]   listed_counter, listed_counter_next;
  logic [BYTE_W-1:0]  first_name_byte, first_name_byte_next;
  logic               match_so_far, match_so_far_next;
  logic [BYTE_W-1:0]  attr_store, attr_store_next;
  logic [WORD_W-1:0]  cluster_store, cluster_store_next;
  logic [WORD_W-1:0]  size_store, size_store_next;

  logic [BYTE_W-1:0]  tgt;
  logic               live, ended;
  logic               a_v, b_v, c_v;
  result_t            a_r, b_r, c_r;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic result_t end_result(input logic [CNT_W-1:0] idx,
                                         input logic [CNT_W-1:0] lc);
    result_t r;
    r = '0;
    r.status       = ST_END;
    r.entry_index  = idx;
    r.listed_count = lc;
    r.scan_done    = 1'b1;
    return r;
  endfunction

  // Target name byte for the current position.
  always_comb begin
    case (byte_position)
      5'd0:    tgt = cfg.name_head[7:0];
      5'd1:    tgt = cfg.name_head[15:8];
      5'd2:    tgt = cfg.name_head[23:16];
      5'd3:    tgt = cfg.name_head[31:24];
      5'd4:    tgt = cfg.name_head[39:32];
      5'd5:    tgt = cfg.name_head[47:40];
      5'd6:    tgt = cfg.name_head[55:48];
      5'd7:    tgt = cfg.name_head[63:56];
      5'd8:    tgt = cfg.name_tail[7:0];
      5'd9:    tgt = cfg.name_tail[15:8];
      5'd10:   tgt = cfg.name_tail[23:16];
      default: tgt = '0;
    endcase
  end

  always_comb begin
    scan_phase_next      = scan_phase;
    byte_position_next   = byte_position;
    entry_counter_next   = entry_counter;
    listed_counter_next  = listed_counter;
    first_name_byte_next = first_name_byte;
    match_so_far_next    = match_so_far;
    attr_store_next      = attr_store;
    cluster_store_next   = cluster_store;
    size_store_next      = size_store;
    live  = 1'b0;
    ended = 1'b0;
    a_v = 1'b0;
    b_v = 1'b0;
    c_v = 1'b0;
    a_r = '0;
    b_r = '0;
    c_r = '0;

    if (scan_phase == PH_ACTIVE) begin
      if (byte_position == '0 && dir_byte == '0) begin
        // terminator entry
        a_v   = 1'b1;
        a_r   = end_result(entry_counter, listed_counter);
        ended = 1'b1;
      end else begin
        if (byte_position == 5'd0) begin
          first_name_byte_next = dir_byte;
        end
        if (byte_position < 5'd11 && fold_case(dir_byte) != fold_case(tgt)) begin
          match_so_far_next = 1'b0;
        end
        if (byte_position == 5'd11) begin
          attr_store_next = dir_byte;
        end
        case (byte_position)
          5'd20: cluster_store_next[23:16] = dir_byte;
          5'd21: cluster_store_next[31:24] = dir_byte;
          5'd26: cluster_store_next[7:0]   = dir_byte;
          5'd27: cluster_store_next[15:8]  = dir_byte;
          5'd28: size_store_next[7:0]      = dir_byte;
          5'd29: size_store_next[15:8]     = dir_byte;
          5'd30: size_store_next[23:16]    = dir_byte;
          5'd31: size_store_next[31:24]    = dir_byte;
          default: ;
        endcase

        if (byte_position == 5'd31) begin
          live = first_name_byte != 8'hE5 && attr_store[3:0] != 4'hF;
          if (!cfg.scan_mode) begin
            if (live && !attr_store[3]) begin
              if (listed_counter != '1) begin
                listed_counter_next = listed_counter + 1'b1;
              end
              a_v = 1'b1;
              a_r.status        = ST_LISTED;
              a_r.entry_index   = entry_counter;
              a_r.listed_count  = listed_counter_next;
              a_r.attr_bits     = attr_store;
              a_r.start_cluster = cluster_store_next;
              a_r.file_size     = size_store_next;
              a_r.scan_done     = 1'b0;
            end
          end else if (live && match_so_far) begin
            a_v = 1'b1;
            a_r.status        = ST_MATCH;
            a_r.entry_index   = entry_counter;
            a_r.listed_count  = listed_counter;
            a_r.attr_bits     = attr_store;
            a_r.start_cluster = cluster_store_next;
            a_r.file_size     = size_store_next;
            a_r.scan_done     = 1'b1;
            ended = 1'b1;
          end
          if (!ended) begin
            if (entry_counter >= ENTRY_LAST) begin
              b_v   = 1'b1;
              b_r   = end_result(entry_counter, listed_counter_next);
              ended = 1'b1;
            end else begin
              entry_counter_next = entry_counter + 1'b1;
            end
          end
          byte_position_next = '0;
          match_so_far_next  = 1'b1;
        end else begin
          byte_position_next = byte_position + 1'b1;
        end
      end

      if (ended) begin
        scan_phase_next = PH_DRAIN;
      end else if (last_byte) begin
        // data ran out with the scan still open
        c_v = 1'b1;
        c_r = end_result(entry_counter_next, listed_counter_next);
      end
    end

    if (last_byte) begin
      scan_phase_next      = PH_ACTIVE;
      byte_position_next   = '0;
      entry_counter_next   = '0;
      listed_counter_next  = '0;
      first_name_byte_next = '0;
      match_so_far_next    = 1'b1;
      attr_store_next      = '0;
      cluster_store_next   = '0;
      size_store_next      = '0;
    end
  end

  // Pack candidates in order; at most two are ever set.
  always_comb begin
    res.v0 = go && (a_v || b_v || c_v);
    res.v1 = go && a_v && (b_v || c_v);
    res.r0 = a_v ? a_r : (b_v ? b_r : c_r);
    res.r1 = b_v ? b_r : c_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase      <= PH_ACTIVE;
      byte_position   <= '0;
      entry_counter   <= '0;
      listed_counter  <= '0;
      first_name_byte <= '0;
      match_so_far    <= 1'b1;
      attr_store      <= '0;
      cluster_store   <= '0;
      size_store      <= '0;
    end else if (go) begin
      scan_phase      <= scan_phase_next;
      byte_position   <= byte_position_next;
      entry_counter   <= entry_counter_next;
      listed_counter  <= listed_counter_next;
      first_name_byte <= first_name_byte_next;
      match_so_far    <= match_so_far_next;
      attr_store      <= attr_store_next;
      cluster_store   <= cluster_store_next;
      size_store      <= size_store_next;
    end
  end

endmodule

// File: sv/fsnds_fifo.sv
// Result FIFO: takes up to two results per cycle, hands out one per beat when popped.
// Depends on fsnds_pkg.
module fsnds_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  fsnds_pkg::result_pair_t       push,
  input  logic                          pop,
  output logic                          room2,
  output logic                          not_empty,
  output fsnds_pkg::result_t            head
);
  import fsnds_pkg::*;

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;
  logic [FIFO_AW-1:0] wr_ptr1;
  logic [1:0]         n_push;

  assign wr_ptr1   = wr_ptr + 1'b1;
  assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
  assign not_empty = count != '0;
  assign room2     = count <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(pop);
    end
  end

endmodule
